FILE: design/loss_and_gradient_eval_macros.svh
// Assertion macros for the loss and gradient evaluator.
// Used by the top level only; no other dependencies.
`ifndef LOSS_AND_GRADIENT_EVAL_MACROS_SVH
`define LOSS_AND_GRADIENT_EVAL_MACROS_SVH
`ifndef ASSERT_OFF
// checked outside reset
`define LGE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("loss_and_gradient_eval assertion failed");
// checked at every edge, reset included
`define LGE_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("loss_and_gradient_eval assertion failed");
`else
`define LGE_ASSERT(lbl, prop)
`define LGE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: design/lge_pkg.sv
// Shared types and constants for the loss and gradient evaluator.
// No dependencies.
package lge_pkg;

    localparam int FifoDepth = 2;
    localparam int DataW     = 32;
    localparam int EpsW      = 16;
    localparam int LossW     = 48;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic CFG_COST_MODE = 1'b0;
    localparam logic CFG_EPSILON   = 1'b1;

    localparam logic MODE_SE = 1'b0;
    localparam logic MODE_CE = 1'b1;

    typedef struct packed {
        logic signed [DataW-1:0] pred;
        logic signed [DataW-1:0] targ;
        logic                    last;
        logic                    mode;
        logic [EpsW-1:0]         eps;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: design/lge_front.sv
// Input side: configuration registers and beat acceptance.
// Tags each beat with the mode and floor in force. Depends on lge_pkg.
module lge_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [15:0]           i_cfg_data,
    input  logic                  i_valid,
    input  logic [31:0]           i_pred,
    input  logic [31:0]           i_targ,
    input  logic                  i_last,
    output logic                  o_ready,
    input  lge_pkg::t_q_status    i_q_status,
    output logic                  o_push,
    output lge_pkg::t_item        o_item
);

    logic        r_mode;
    logic [15:0] r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= lge_pkg::MODE_SE;
            r_eps  <= 16'd7;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lge_pkg::CFG_COST_MODE: r_mode <= i_cfg_data[0];
                lge_pkg::CFG_EPSILON:   r_eps  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_ready = !i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    always_comb begin
        o_item.pred = i_pred;
        o_item.targ = i_targ;
        o_item.last = i_last;
        o_item.mode = r_mode;
        // a zero floor acts as one
        o_item.eps  = (r_eps == 16'd0) ? 16'd1 : r_eps;
    end

endmodule

FILE: design/lge_fifo.sv
// Short queue between the front and back parts.
// Holds tagged items; depends on lge_pkg.
module lge_fifo #(
    parameter int DEPTH = lge_pkg::FifoDepth
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lge_pkg::t_item     i_item,
    input  logic               i_pop,
    output lge_pkg::t_item     o_item,
    output lge_pkg::t_q_status o_status
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    lge_pkg::t_item r_mem [DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_item         = r_mem[r_rd];
    assign o_status.full  = (r_cnt == CntW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);

endmodule

FILE: design/lge_back.sv
// Back part: sequencer with one shared 32x32 multiplier, a radix-2 divider
// and an iterative log2 by squaring. Holds the loss sum and the output beat.
// Depends on lge_pkg.
module lge_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lge_pkg::t_item     i_item,
    input  lge_pkg::t_q_status i_status,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_delta,
    output logic [47:0]        o_total,
    output logic               o_last
);

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_SQ   = 14'b00000000000010,
        S_DEN  = 14'b00000000000100,
        S_DIV  = 14'b00000000001000,
        S_DRND = 14'b00000000010000,
        S_LNLD = 14'b00000000100000,
        S_NORM = 14'b00000001000000,
        S_LNSQ = 14'b00000010000000,
        S_LNF  = 14'b00000100000000,
        S_LNK  = 14'b00001000000000,
        S_CE1  = 14'b00010000000000,
        S_CE2  = 14'b00100000000000,
        S_CET  = 14'b01000000000000,
        S_ACC  = 14'b10000000000000
    } t_state;

    t_state             r_state;
    logic signed [31:0] r_p;
    logic signed [31:0] r_t;
    logic               r_last;
    logic [15:0]        r_eps;
    logic               r_neg;
    logic [31:0]        r_mag;
    logic [31:0]        r_delta;
    logic signed [49:0] r_term;
    logic [31:0]        r_div;
    logic [63:0]        r_quo;
    logic [31:0]        r_rem;
    logic [5:0]         r_cnt;
    logic [32:0]        r_m;
    logic [5:0]         r_k;
    logic [31:0]        r_frac;
    logic [31:0]        r_lnf;
    logic               r_which;
    logic signed [23:0] r_ln_a;
    logic signed [23:0] r_ln_b;
    logic signed [57:0] r_ce;
    logic signed [47:0] r_acc;
    logic               r_ovalid;
    logic [31:0]        r_odelta;
    logic [47:0]        r_ototal;
    logic               r_olast;

    logic [31:0]        w_mul_a;
    logic [31:0]        w_mul_b;
    logic [63:0]        w_prod;
    logic [32:0]        w_d;
    logic signed [33:0] w_w;
    logic [31:0]        w_abs_p;
    logic [31:0]        w_abs_t;
    logic [31:0]        w_abs_w;
    logic [23:0]        w_abs_lna;
    logic [23:0]        w_abs_lnb;
    logic signed [6:0]  w_km;
    logic [4:0]         w_km_mag;
    logic               w_out_free;
    logic               w_load;

    // signed 32-bit magnitude, -2^31 maps to 2^31
    function automatic logic [31:0] abs32(input logic [31:0] x);
        abs32 = x[31] ? (~x + 32'd1) : x;
    endfunction

    function automatic logic [23:0] abs24(input logic [23:0] x);
        abs24 = x[23] ? (~x + 24'd1) : x;
    endfunction

    assign w_d       = {i_item.targ[31], i_item.targ} - {i_item.pred[31], i_item.pred};
    assign w_w       = 34'sd65536 - $signed({{2{r_t[31]}}, r_t});
    assign w_abs_p   = abs32(r_p);
    assign w_abs_t   = abs32(r_t);
    assign w_abs_w   = w_w[33] ? 32'(-w_w) : w_w[31:0];
    assign w_abs_lna = abs24(r_ln_a);
    assign w_abs_lnb = abs24(r_ln_b);
    assign w_km      = $signed({1'b0, r_k}) - 7'sd16;
    assign w_km_mag  = w_km[6] ? 5'(-w_km) : w_km[4:0];
    assign w_out_free = !r_ovalid || i_ready;
    assign w_load    = (r_state == S_ACC) && w_out_free;

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_SQ:    begin w_mul_a = r_mag;               w_mul_b = r_mag;    end
            S_DEN:   begin w_mul_a = w_abs_p;             w_mul_b = w_abs_p;  end
            S_LNSQ:  begin w_mul_a = r_m[31:0];           w_mul_b = r_m[31:0]; end
            S_LNF:   begin w_mul_a = r_frac;              w_mul_b = lge_pkg::LN2_Q32; end
            S_LNK:   begin w_mul_a = {27'd0, w_km_mag};   w_mul_b = lge_pkg::LN2_Q32; end
            S_CE1:   begin w_mul_a = w_abs_t;             w_mul_b = {8'd0, w_abs_lna}; end
            S_CE2:   begin w_mul_a = w_abs_w;             w_mul_b = {8'd0, w_abs_lnb}; end
            default: begin w_mul_a = '0;                  w_mul_b = '0;       end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // squared-error term, rounded half up
    logic [64:0] w_sq_sum;
    assign w_sq_sum = {1'b0, w_prod} + 65'h10000;

    // saturated t-p
    logic [31:0] w_dsat;
    always_comb begin
        if (r_neg) begin
            w_dsat = (r_mag > 32'h80000000) ? 32'h80000000 : (~r_mag + 32'd1);
        end else begin
            w_dsat = (r_mag > 32'h7FFFFFFF) ? 32'h7FFFFFFF : r_mag;
        end
    end

    // denominator p - p*p in Q.32, floored at eps
    logic signed [65:0] w_den;
    logic signed [65:0] w_eps32;
    assign w_den   = $signed({{18{r_p[31]}}, r_p, 16'd0}) - $signed({2'b00, w_prod});
    assign w_eps32 = $signed({18'd0, r_eps, 32'd0}) >>> 16;

    // one divider step
    logic [32:0] w_rsh;
    logic        w_ge;
    assign w_rsh = {r_rem, r_quo[63]};
    assign w_ge  = (w_rsh >= {1'b0, r_div});

    // quotient rounding and clamp
    logic        w_rnd;
    logic [64:0] w_q1;
    logic [31:0] w_qc;
    logic [31:0] w_cedelta;
    assign w_rnd = ({r_rem, 1'b0} >= {1'b0, r_div});
    assign w_q1  = {1'b0, r_quo} + {64'd0, w_rnd};
    assign w_qc  = (w_q1 > 65'h80000000) ? 32'h80000000 : w_q1[31:0];
    assign w_cedelta = r_neg ? (~w_qc + 32'd1)
                             : ((w_qc == 32'h80000000) ? 32'h7FFFFFFF : w_qc);

    // log arguments, clamped at eps
    logic signed [33:0] w_eps_ext;
    logic signed [33:0] w_xa;
    logic signed [33:0] w_xb;
    logic signed [33:0] w_xs;
    logic [32:0]        w_x;
    assign w_eps_ext = $signed({18'd0, r_eps});
    assign w_xa = $signed({{2{r_p[31]}}, r_p}) + w_eps_ext;
    assign w_xb = 34'sd65536 - $signed({{2{r_p[31]}}, r_p}) + w_eps_ext;
    assign w_xs = r_which ? w_xb : w_xa;
    assign w_x  = (w_xs < w_eps_ext) ? {17'd0, r_eps} : w_xs[32:0];

    // one squaring step
    logic [32:0] w_s;
    assign w_s = w_prod[63:31];

    // integer part plus fraction, rounded to Q16.16
    logic signed [39:0] w_kc;
    logic signed [39:0] w_lv;
    logic signed [39:0] w_lr;
    assign w_kc = w_km[6] ? -$signed({1'b0, w_prod[38:0]}) : $signed({1'b0, w_prod[38:0]});
    assign w_lv = w_kc + $signed({8'd0, r_lnf});
    assign w_lr = (w_lv + 40'sd32768) >>> 16;

    // cross-entropy products
    logic signed [57:0] w_pr;
    logic signed [57:0] w_ce1;
    logic signed [57:0] w_ce2;
    assign w_pr  = $signed({4'd0, w_prod[53:0]});
    assign w_ce1 = (r_t[31] ^ r_ln_a[23]) ? -w_pr : w_pr;
    assign w_ce2 = r_ce + ((w_w[33] ^ r_ln_b[23]) ? -w_pr : w_pr);

    logic signed [57:0] w_cet;
    assign w_cet = (-r_ce + 58'sd32768) >>> 16;

    // accumulate with saturation
    logic signed [50:0] w_sum;
    logic signed [47:0] w_sat;
    assign w_sum = $signed({{3{r_acc[47]}}, r_acc}) + $signed({r_term[49], r_term});
    always_comb begin
        if (w_sum > 51'sd140737488355327) begin
            w_sat = 48'sh7FFFFFFFFFFF;
        end else if (w_sum < -51'sd140737488355328) begin
            w_sat = 48'sh800000000000;
        end else begin
            w_sat = w_sum[47:0];
        end
    end

    assign o_pop = (r_state == S_IDLE) && !i_status.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_acc    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_status.empty) begin
                        r_p     <= i_item.pred;
                        r_t     <= i_item.targ;
                        r_last  <= i_item.last;
                        r_eps   <= i_item.eps;
                        r_neg   <= w_d[32];
                        r_mag   <= w_d[32] ? 32'(-w_d) : w_d[31:0];
                        r_state <= (i_item.mode == lge_pkg::MODE_CE) ? S_DEN : S_SQ;
                    end
                end
                S_SQ: begin
                    r_term  <= $signed({2'b00, w_sq_sum[64:17]});
                    r_delta <= w_dsat;
                    r_state <= S_ACC;
                end
                S_DEN: begin
                    r_div   <= (w_den < w_eps32) ? w_eps32[31:0] : w_den[31:0];
                    r_quo   <= {r_mag, 32'd0};
                    r_rem   <= '0;
                    r_cnt   <= 6'd63;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_ge ? 32'(w_rsh - {1'b0, r_div}) : w_rsh[31:0];
                    r_quo <= {r_quo[62:0], w_ge};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_state <= S_DRND;
                    end
                end
                S_DRND: begin
                    r_delta <= w_cedelta;
                    r_which <= 1'b0;
                    r_state <= S_LNLD;
                end
                S_LNLD: begin
                    if (w_x[32]) begin
                        r_m     <= {1'b0, w_x[32:1]};
                        r_k     <= 6'd32;
                        r_cnt   <= 6'd31;
                        r_frac  <= '0;
                        r_state <= S_LNSQ;
                    end else begin
                        r_m     <= w_x;
                        r_k     <= 6'd31;
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    // shift left until the top bit lands at bit 31
                    if (r_m[31]) begin
                        r_cnt   <= 6'd31;
                        r_frac  <= '0;
                        r_state <= S_LNSQ;
                    end else begin
                        r_m <= {r_m[31:0], 1'b0};
                        r_k <= r_k - 6'd1;
                    end
                end
                S_LNSQ: begin
                    r_m    <= w_s[32] ? {1'b0, w_s[32:1]} : w_s;
                    r_frac <= {r_frac[30:0], w_s[32]};
                    r_cnt  <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_state <= S_LNF;
                    end
                end
                S_LNF: begin
                    r_lnf   <= w_prod[63:32];
                    r_state <= S_LNK;
                end
                S_LNK: begin
                    if (r_which) begin
                        r_ln_b  <= w_lr[23:0];
                        r_state <= S_CE1;
                    end else begin
                        r_ln_a  <= w_lr[23:0];
                        r_which <= 1'b1;
                        r_state <= S_LNLD;
                    end
                end
                S_CE1: begin
                    r_ce    <= w_ce1;
                    r_state <= S_CE2;
                end
                S_CE2: begin
                    r_ce    <= w_ce2;
                    r_state <= S_CET;
                end
                S_CET: begin
                    r_term  <= 50'(w_cet);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    // hold until the output register is free
                    if (w_out_free) begin
                        r_odelta <= r_delta;
                        r_olast  <= r_last;
                        if (r_last) begin
                            r_ototal <= w_sat;
                            r_acc    <= '0;
                        end else begin
                            r_ototal <= '0;
                            r_acc    <= w_sat;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_delta = r_odelta;
    assign o_total = r_ototal;
    assign o_last  = r_olast;

endmodule

FILE: design/loss_and_gradient_eval.sv
// Loss and gradient evaluator: squared error or binary cross-entropy.
// Top level; uses lge_pkg, lge_front, lge_fifo, lge_back and the macro header.
//
// Input stream: one beat per element, tdata = {target, prediction} (Q16.16),
// tlast marks the last element of a vector. Output stream: one beat per
// input beat, tdata = {total_loss (Q32.16), delta (Q16.16)}, tlast echoes the
// input mark; total_loss is nonzero only on the last beat, which also clears
// the running sum. Configuration: i_cfg_we with i_cfg_idx 0 writes the mode
// (bit 0), index 1 writes epsilon; write only while the block is idle.
// Squared-error items pass through the load, square and accumulate states
// in the back part. Cross-entropy items take a 64-step radix-2 divide and two
// logs, each a normalize and 32 squarings on the shared 32x32 multiplier.
// A queue of FIFO_DEPTH items lets the front keep taking beats meanwhile.
// When the receiver stalls, the result holds in the output register and the
// back part waits; the queue fills and then tready drops.
// Reset (synchronous, active low) clears the running sum, the queue and the
// output, and sets mode 0 and epsilon 7.
`include "loss_and_gradient_eval_macros.svh"
module loss_and_gradient_eval #(
    parameter int FIFO_DEPTH = lge_pkg::FifoDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] prediction, [63:32] target
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [31:0] delta, [79:32] total_loss
    output logic        m_axis_tlast    // last_out
);

    lge_pkg::t_item     w_push_item;
    lge_pkg::t_item     w_head_item;
    lge_pkg::t_q_status w_q_status;
    logic               w_push;
    logic               w_pop;
    logic [31:0]        w_delta;
    logic [47:0]        w_total;

    lge_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .i_pred     (s_axis_tdata[31:0]),
        .i_targ     (s_axis_tdata[63:32]),
        .i_last     (s_axis_tlast),
        .o_ready    (s_axis_tready),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    lge_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_item   (w_head_item),
        .o_status (w_q_status)
    );

    lge_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_head_item),
        .i_status (w_q_status),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_delta  (w_delta),
        .o_total  (w_total),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {w_total, w_delta};

    `LGE_ASSERT(a_push_not_full, w_push |-> !w_q_status.full)
    `LGE_ASSERT(a_pop_not_empty, w_pop |-> !w_q_status.empty)
    `LGE_ASSERT(a_total_only_last, (m_axis_tvalid && !m_axis_tlast) |-> (w_total == 48'd0))
    `LGE_ASSERT_ALWAYS(a_no_out_after_reset, !i_rst_n |=> !m_axis_tvalid)

endmodule
